[rtl/core/pps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  // Default width of the busy timeout register and of the wait counter.
  localparam int unsigned TIMEOUT_BITS_DEF = 21;

  localparam int unsigned BUSY_TIMEOUT_RST  = 2000000;
  localparam logic [15:0] STROBE_TICKS_RST  = 16'd1;
  localparam logic        CRLF_ENABLE_RST   = 1'b0;
  localparam logic [7:0]  TIMEOUT_LIMIT_RST = 8'd10;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam int unsigned CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BUSY_TIMEOUT  = 2'd0,
    REG_STROBE_TICKS  = 2'd1,
    REG_CRLF_ENABLE   = 2'd2,
    REG_TIMEOUT_LIMIT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_SENT    = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_WAIT   = 4'b0010,
    PH_SETUP  = 4'b0100,
    PH_STROBE = 4'b1000
  } phase_t;

  // Fixed-width configuration fields handed to the sequencer.
  typedef struct packed {
    logic [15:0] strobe_ticks;
    logic        crlf_enable;
    logic [7:0]  timeout_limit;
  } misc_cfg_t;

  // Input item as carried on in_tdata, last field in the lowest bit.
  typedef struct packed {
    logic [5:0] pad;
    logic       not_busy;
    logic [7:0] byte_value;
    logic       byte_valid;
  } in_item_t;

  // Result item as carried on out_tdata, last field in the lowest bit.
  typedef struct packed {
    logic [3:0] pad;
    status_t    status;
    logic       strobe_res;
    logic [7:0] data_out;
    logic       accept;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/pps_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module pps_cfg
  import pps_pkg::*;
#(
  parameter int unsigned TIMEOUT_BITS = TIMEOUT_BITS_DEF,
  parameter int unsigned CFG_DATA_W   = (TIMEOUT_BITS > 16) ? TIMEOUT_BITS : 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
  output logic      [TIMEOUT_BITS-1:0] busy_timeout,
  output misc_cfg_t                    misc_cfg
);

  localparam logic [TIMEOUT_BITS-1:0] BusyTimeoutRst = TIMEOUT_BITS'(BUSY_TIMEOUT_RST);

  logic [TIMEOUT_BITS-1:0] busy_timeout_r;
  misc_cfg_t               misc_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_timeout_r           <= BusyTimeoutRst;
      misc_cfg_r.strobe_ticks  <= STROBE_TICKS_RST;
      misc_cfg_r.crlf_enable   <= CRLF_ENABLE_RST;
      misc_cfg_r.timeout_limit <= TIMEOUT_LIMIT_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_BUSY_TIMEOUT:  busy_timeout_r           <= cfg_wdata[TIMEOUT_BITS-1:0];
        REG_STROBE_TICKS:  misc_cfg_r.strobe_ticks  <= cfg_wdata[15:0];
        REG_CRLF_ENABLE:   misc_cfg_r.crlf_enable   <= cfg_wdata[0];
        REG_TIMEOUT_LIMIT: misc_cfg_r.timeout_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign busy_timeout = busy_timeout_r;
  assign misc_cfg     = misc_cfg_r;

endmodule

`default_nettype wire

[rtl/core/pps_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module pps_seq
  import pps_pkg::*;
#(
  parameter int unsigned TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step,
  input  wire in_item_t                item,
  input  wire logic [TIMEOUT_BITS-1:0] busy_timeout,
  input  wire misc_cfg_t               misc_cfg,
  output out_item_t                    result
);

  phase_t                  phase_r, phase_nxt;
  logic [TIMEOUT_BITS-1:0] wait_count_r, wait_count_nxt, wait_inc;
  logic [15:0]             pulse_count_r, pulse_count_nxt;
  logic [7:0]              held_byte_r, held_byte_nxt;
  logic                    lf_pending_r, lf_pending_nxt;
  logic [7:0]              timeout_runs_r, timeout_runs_nxt, runs_inc;
  logic                    disabled_r, disabled_nxt;

  // Saturating increments used in the wait phase.
  assign wait_inc = (wait_count_r == '1) ? wait_count_r : wait_count_r + 1'b1;
  assign runs_inc = (timeout_runs_r == 8'hFF) ? timeout_runs_r : timeout_runs_r + 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    wait_count_nxt   = wait_count_r;
    pulse_count_nxt  = pulse_count_r;
    held_byte_nxt    = held_byte_r;
    lf_pending_nxt   = lf_pending_r;
    timeout_runs_nxt = timeout_runs_r;
    disabled_nxt     = disabled_r;
    result           = '0;

    case (phase_r)
      PH_IDLE: begin
        if (item.byte_valid) begin
          if (disabled_r) begin
            result.status = ST_REFUSED;
          end else begin
            result.accept  = 1'b1;
            wait_count_nxt = '0;
            phase_nxt      = PH_WAIT;
            if (misc_cfg.crlf_enable && item.byte_value == CHAR_LF) begin
              held_byte_nxt  = CHAR_CR;
              lf_pending_nxt = 1'b1;
            end else begin
              held_byte_nxt  = item.byte_value;
              lf_pending_nxt = 1'b0;
            end
          end
        end
      end
      PH_WAIT: begin
        if (item.not_busy) begin
          timeout_runs_nxt = '0;
          pulse_count_nxt  = '0;
          result.data_out  = held_byte_r;
          phase_nxt        = PH_SETUP;
        end else begin
          wait_count_nxt = wait_inc;
          if (wait_inc >= busy_timeout) begin
            result.status    = ST_TIMEOUT;
            lf_pending_nxt   = 1'b0;
            timeout_runs_nxt = runs_inc;
            if (misc_cfg.timeout_limit != 8'd0 && runs_inc >= misc_cfg.timeout_limit) begin
              disabled_nxt = 1'b1;
            end
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_SETUP: begin
        result.data_out = held_byte_r;
        if (pulse_count_r < misc_cfg.strobe_ticks) begin
          pulse_count_nxt = pulse_count_r + 16'd1;
        end else begin
          result.strobe_res = 1'b1;
          pulse_count_nxt   = 16'd1;
          phase_nxt         = PH_STROBE;
        end
      end
      PH_STROBE: begin
        result.data_out = held_byte_r;
        if (pulse_count_r < misc_cfg.strobe_ticks) begin
          result.strobe_res = 1'b1;
          pulse_count_nxt   = pulse_count_r + 16'd1;
        end else begin
          result.status = ST_SENT;
          if (lf_pending_r) begin
            // Carriage return is out; the line feed follows with its own wait.
            lf_pending_nxt = 1'b0;
            held_byte_nxt  = CHAR_LF;
            wait_count_nxt = '0;
            phase_nxt      = PH_WAIT;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      wait_count_r   <= '0;
      pulse_count_r  <= '0;
      held_byte_r    <= '0;
      lf_pending_r   <= 1'b0;
      timeout_runs_r <= '0;
      disabled_r     <= 1'b0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      wait_count_r   <= wait_count_nxt;
      pulse_count_r  <= pulse_count_nxt;
      held_byte_r    <= held_byte_nxt;
      lf_pending_r   <= lf_pending_nxt;
      timeout_runs_r <= timeout_runs_nxt;
      disabled_r     <= disabled_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/parallel_printer_byte_sender.sv]
// Parallel printer byte sender.
// Each item on the in_ channel is one tick of the printer port: the sampled
// not-busy line and an optional byte offer. Every accepted item produces
// exactly one result item on the out_ channel with the accept flag, the
// value for the data lines, the strobe level and a status code (sent,
// timeout, refused because disabled).
// The cfg_ port writes the busy timeout, strobe width, console line-feed
// mode and timeout limit; the user must write it only while no items are in
// flight, and the block itself does not enforce this. An item is captured in
// an input register, processed by the sequencer once the output register is
// free, and its result lands in the output register. One item is accepted per
// cycle while in_tready is high; the sequencer state advances once per item.
// When the receiver stalls, the output register holds its result and the
// input register fills; in_tready drops only when both are occupied.
// Reset (synchronous, active low) empties both registers, returns the
// sequencer to idle, clears the timeout run count and re-enables the sender,
// and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module parallel_printer_byte_sender
  import pps_pkg::*;
#(
  parameter int unsigned TIMEOUT_BITS = TIMEOUT_BITS_DEF,
  parameter int unsigned CFG_DATA_W   = (TIMEOUT_BITS > 16) ? TIMEOUT_BITS : 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // byte_valid, byte_value, not_busy
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [15:0]           out_tdata,  // accept, data_out, strobe_res, status
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TIMEOUT_BITS-1:0] busy_timeout;
  misc_cfg_t               misc_cfg;
  logic                    in_valid_r;
  in_item_t                in_item_r;
  logic                    out_valid_r;
  out_item_t               out_item_r;
  out_item_t               result;
  logic                    out_free;
  logic                    step;

  pps_cfg #(
    .TIMEOUT_BITS(TIMEOUT_BITS),
    .CFG_DATA_W  (CFG_DATA_W)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .busy_timeout(busy_timeout),
    .misc_cfg    (misc_cfg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item_t'(in_tdata);
    end
  end

  pps_seq #(
    .TIMEOUT_BITS(TIMEOUT_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_item_r),
    .busy_timeout(busy_timeout),
    .misc_cfg    (misc_cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

endmodule

`default_nettype wire

[rtl/core/pps_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module pps_checker
  import pps_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Taking a byte never coincides with a completion, timeout or refusal.
  a_accept_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[11:10] == ST_NONE)
    else $error("accept together with a status");

  // The tick that takes a byte comes from idle, where the data lines are low.
  a_accept_data_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[9:1] == 9'd0)
    else $error("accept with data or strobe driven");

  // While the strobe is high nothing is reported.
  a_strobe_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[11:10] == ST_NONE)
    else $error("status during strobe");

endmodule

bind parallel_printer_byte_sender pps_checker u_pps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire
